@@ hdl/pulse_heart_rate_monitor_unit_assert.svh @@
// Assertion macros shared by the checker of the pulse heart-rate monitor.
`ifndef PULSE_HEART_RATE_MONITOR_UNIT_ASSERT_SVH
`define PULSE_HEART_RATE_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define PHRM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phrm checker: same-cycle rule violated");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define PHRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phrm checker: next-cycle rule violated");

`endif

@@ hdl/phrm_pkg.sv @@
// Types, constants and codes shared by the pulse heart-rate monitor modules.
package phrm_pkg;

    localparam int TIME_BITS_DEFAULT = 32;

    localparam int SAMPLE_W = 12;
    localparam int TS_W     = 32;
    localparam int IVL_W    = 16;
    localparam int RATE_W   = 16;
    localparam int MODE_W   = 2;
    localparam int HZ_W     = 9;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_IVL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IVL   = 2'd2;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2000;
    localparam logic [IVL_W-1:0]    MIN_IVL_RESET   = 16'd300;
    localparam logic [IVL_W-1:0]    MAX_IVL_RESET   = 16'd2000;

    localparam logic [RATE_W-1:0] BEAT_MINUTE_MS = 16'd60000;

    localparam logic [RATE_W-1:0] BAND_LOW           = 16'd50;
    localparam logic [RATE_W-1:0] BAND_NORMAL_HIGH   = 16'd100;
    localparam logic [RATE_W-1:0] BAND_ELEVATED_HIGH = 16'd130;

    localparam logic [MODE_W-1:0] MODE_STANDARD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INCREASED  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DIAGNOSTIC = 2'd3;

    localparam logic [HZ_W-1:0] HZ_STANDARD   = 9'd50;
    localparam logic [HZ_W-1:0] HZ_INCREASED  = 9'd250;
    localparam logic [HZ_W-1:0] HZ_DIAGNOSTIC = 9'd500;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_WRITE
    } phrm_state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hdl/phrm_div.sv @@
// Iterative restoring divider: one minute in milliseconds over the beat interval.
module phrm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  phrm_pkg::div_ctrl_t          ctrl,
    input  logic [phrm_pkg::IVL_W-1:0]   divisor,
    output phrm_pkg::div_stat_t          stat,
    output logic [phrm_pkg::RATE_W-1:0]  quotient
);
    import phrm_pkg::*;

    localparam int CNT_W = $clog2(RATE_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IVL_W-1:0]    rem_reg, rem_next;
    logic [RATE_W-1:0]   quo_reg, quo_next;
    logic [IVL_W-1:0]    dvs_reg, dvs_next;

    logic [IVL_W:0]      shifted;
    logic [IVL_W+1:0]    trial;
    logic                fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[RATE_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = ~trial[IVL_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RATE_W - 1);
            rem_next  = '0;
            quo_next  = BEAT_MINUTE_MS;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // One quotient bit per cycle, most significant first.
            rem_next = fits ? trial[IVL_W-1:0] : shifted[IVL_W-1:0];
            quo_next = {quo_reg[RATE_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ hdl/phrm_band.sv @@
// Maps the heart rate onto a sampling mode and its sampling rate.
module phrm_band (
    input  logic [phrm_pkg::RATE_W-1:0] rate,
    output logic [phrm_pkg::MODE_W-1:0] mode,
    output logic [phrm_pkg::HZ_W-1:0]   hz
);
    import phrm_pkg::*;

    always_comb
    begin
        if (rate >= BAND_LOW && rate <= BAND_NORMAL_HIGH)
            mode = MODE_STANDARD;
        else if (rate != '0 && rate < BAND_LOW)
            mode = MODE_INCREASED;
        else if (rate > BAND_NORMAL_HIGH && rate <= BAND_ELEVATED_HIGH)
            mode = MODE_INCREASED;
        else if (rate > BAND_ELEVATED_HIGH)
            mode = MODE_DIAGNOSTIC;
        else
            mode = MODE_STANDARD;

        case (mode)
            MODE_INCREASED:  hz = HZ_INCREASED;
            MODE_DIAGNOSTIC: hz = HZ_DIAGNOSTIC;
            default:         hz = HZ_STANDARD;
        endcase
    end

endmodule

@@ hdl/pulse_heart_rate_monitor_unit.sv @@
// Pulse heart-rate monitor: threshold beat detector with an iterative rate divider.
//
// Input stream (s_*): one word per sensor sample, carrying the 12-bit reading and
// its 32-bit millisecond timestamp. Output stream (m_*): one word per sample with
// the current heart rate, sampling mode and sampling rate, plus flags in m_tuser
// telling whether the sample was a beat and whether the rate was recomputed.
// Configuration (cfg_*): register 0 threshold, 1 minimum and 2 maximum interval;
// write only while no sample is in flight. cfg_ready is always high.
//
// A sample is accepted in IDLE, evaluated in the next cycle, and its result is
// loaded into the output register in WRITE once that register is free; a sample
// without a rate update goes from EVAL straight to WRITE. A beat with an interval
// inside the limits first runs the restoring divider in DIV: a start, then the
// quotient bits one at a time, most significant first, and a step to take the
// quotient. The next sample can be accepted once the result is loaded and the
// state is back in IDLE, not while the last one is still being worked on.
// If the receiver stalls, the result waits in the output register while the next
// sample is accepted and evaluated; that one then waits until the register drains.
// Reset clears the edge state, last beat time and rate, and restores the reset
// values of the three configuration registers.
module pulse_heart_rate_monitor_unit #(
    parameter int TIME_BITS = phrm_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [phrm_pkg::IN_DATA_W-1:0]    s_tdata,   // sample[11:0], timestamp_ms[43:12]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [phrm_pkg::OUT_DATA_W-1:0]   m_tdata,   // bpm[15:0], mode[17:16], hz[26:18]
    output logic [phrm_pkg::OUT_USER_W-1:0]   m_tuser,   // beat_detected, rate_updated
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [phrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [phrm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import phrm_pkg::*;

    localparam int TS_USED = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;

    phrm_state_t            state_reg, state_next;

    logic [SAMPLE_W-1:0]    threshold_reg;
    logic [IVL_W-1:0]       min_ivl_reg;
    logic [IVL_W-1:0]       max_ivl_reg;

    logic                   pulse_high_reg, pulse_high_next;
    logic [TIME_BITS-1:0]   last_beat_reg, last_beat_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;

    logic [SAMPLE_W-1:0]    sample_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic                   beat_reg, beat_next;
    logic                   upd_reg, upd_next;
    logic [IVL_W-1:0]       gap_reg, gap_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_USER_W-1:0]  out_user_reg;

    logic                   in_fire;
    logic                   beat;
    logic [TIME_BITS-1:0]   gap;
    logic                   in_window;
    logic                   out_load;

    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;
    logic [RATE_W-1:0]      quotient;
    logic [MODE_W-1:0]      mode;
    logic [HZ_W-1:0]        hz;

    phrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .divisor  (gap_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    phrm_band u_band (
        .rate (rate_reg),
        .mode (mode),
        .hz   (hz)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Interval arithmetic wraps at the timestamp width.
    assign beat      = (sample_reg > threshold_reg) && !pulse_high_reg;
    assign gap       = now_reg - last_beat_reg;
    assign in_window = (last_beat_reg != '0) && (gap > TIME_BITS'(min_ivl_reg))
                       && (gap < TIME_BITS'(max_ivl_reg));

    assign out_load  = (state_reg == ST_WRITE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next      = state_reg;
        pulse_high_next = pulse_high_reg;
        last_beat_next  = last_beat_reg;
        rate_next       = rate_reg;
        beat_next       = beat_reg;
        upd_next        = upd_reg;
        gap_next        = gap_reg;
        div_ctrl.start  = 1'b0;
        out_valid_next  = out_valid_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                beat_next = beat;
                upd_next  = beat && in_window;
                gap_next  = gap[IVL_W-1:0];
                if (beat)
                begin
                    pulse_high_next = 1'b1;
                    last_beat_next  = now_reg;
                end
                if (sample_reg < threshold_reg)
                    pulse_high_next = 1'b0;
                state_next = (beat && in_window) ? ST_DIV : ST_WRITE;
            end
            ST_DIV:
            begin
                // The divisor input, gap_reg, was loaded in the evaluate cycle.
                if (!div_stat.busy && !div_stat.done)
                    div_ctrl.start = 1'b1;
                if (div_stat.done)
                begin
                    rate_next  = quotient;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            threshold_reg  <= THRESHOLD_RESET;
            min_ivl_reg    <= MIN_IVL_RESET;
            max_ivl_reg    <= MAX_IVL_RESET;
            pulse_high_reg <= 1'b0;
            last_beat_reg  <= '0;
            rate_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pulse_high_reg <= pulse_high_next;
            last_beat_reg  <= last_beat_next;
            rate_reg       <= rate_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD: threshold_reg <= cfg_data[SAMPLE_W-1:0];
                    REG_MIN_IVL:   min_ivl_reg   <= cfg_data;
                    REG_MAX_IVL:   max_ivl_reg   <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            now_reg    <= TIME_BITS'(s_tdata[SAMPLE_W +: TS_USED]);
        end
        beat_reg <= beat_next;
        upd_reg  <= upd_next;
        gap_reg  <= gap_next;
        if (out_load)
        begin
            out_data_reg <= {5'b0, hz, mode, rate_reg};
            out_user_reg <= {upd_reg, beat_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ hdl/phrm_checker.sv @@
// Port-level checker for the pulse heart-rate monitor, bound to the top level.
module phrm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [phrm_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [phrm_pkg::OUT_USER_W-1:0]   m_tuser
);
    import phrm_pkg::*;

    `include "pulse_heart_rate_monitor_unit_assert.svh"

    logic [RATE_W-1:0] rate_bpm;
    logic [MODE_W-1:0] smode;
    logic [HZ_W-1:0]   shz;

    assign rate_bpm = m_tdata[RATE_W-1:0];
    assign smode    = m_tdata[RATE_W +: MODE_W];
    assign shz      = m_tdata[RATE_W+MODE_W +: HZ_W];

    // A sample is worked on alone: no second accept right after one.
    `PHRM_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

    // A waiting word stays until it is taken.
    `PHRM_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid)

    // The sampling rate always matches the reported mode.
    `PHRM_ASSERT_NOW(a_mode_rate, m_tvalid,
        (smode == MODE_STANDARD && shz == HZ_STANDARD) ||
        (smode == MODE_INCREASED && shz == HZ_INCREASED) ||
        (smode == MODE_DIAGNOSTIC && shz == HZ_DIAGNOSTIC))

    // A rate is recomputed only on a beat.
    `PHRM_ASSERT_NOW(a_update_on_beat, m_tvalid && m_tuser[1], m_tuser[0])

    // No rate yet means standard monitoring.
    `PHRM_ASSERT_NOW(a_zero_rate_mode, m_tvalid && rate_bpm == '0,
        smode == MODE_STANDARD)

endmodule

bind pulse_heart_rate_monitor_unit phrm_checker u_phrm_checker (.*);
